// ===== rtl/core/yad_pkg.sv =====
package yad_pkg;

    localparam int MAX_CLASSES_DEF = 256;
    localparam int SIG_ENTRIES_DEF = 4096;
    localparam int LOGIT_FRAC_DEF  = 8;

    localparam int CMD_Q_DEPTH = 4;
    localparam int LUT_IDX_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic {
        MODE_BOX   = 1'b0,
        MODE_CLASS = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH  = 3'd0,
        REG_NET_W   = 3'd1,
        REG_NET_H   = 3'd2,
        REG_GRID_W  = 3'd3,
        REG_GRID_H  = 3'd4,
        REG_SCALE_X = 3'd5,
        REG_SCALE_Y = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] logit_x;
        logic signed [15:0] logit_y;
        logic signed [15:0] logit_w;
        logic signed [15:0] logit_h;
        logic signed [15:0] logit_obj;
        logic [7:0]         cell_col;
        logic [7:0]         cell_row;
        logic [11:0]        prior_w;
        logic [11:0]        prior_h;
        logic signed [15:0] class_logit;
        logic               last_class;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [15:0]        score;
        logic [7:0]         class_index;
    } t_out_word;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [12:0] net_width;
        logic [12:0] net_height;
        logic [7:0]  grid_width;
        logic [7:0]  grid_height;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        score_threshold: 16'd16384,
        net_width:       13'd640,
        net_height:      13'd640,
        grid_width:      8'd80,
        grid_height:     8'd80,
        scale_x:         16'd256,
        scale_y:         16'd256
    };

    // command word from the front to the back
    typedef struct packed {
        logic                 is_box;
        logic                 last;
        logic [LUT_IDX_W-1:0] lut_idx;
        logic signed [15:0]   logit_x;
        logic signed [15:0]   logit_y;
        logic signed [15:0]   logit_w;
        logic signed [15:0]   logit_h;
        logic [7:0]           cell_col;
        logic [7:0]           cell_row;
        logic [11:0]          prior_w;
        logic [11:0]          prior_h;
    } t_cmd;

    // table index of a raw logit, clamped to the table
    function automatic logic [LUT_IDX_W-1:0] sig_index(input logic signed [15:0] raw,
                                                       input int entries);
        int i;
        i = int'(raw) + (entries >> 1);
        if (i < 0) i = 0;
        if (i > entries - 1) i = entries - 1;
        return i[LUT_IDX_W-1:0];
    endfunction

    // shift and subtract division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-2^-frac) in Q32 from a Q62 series
    function automatic logic [63:0] sig_ratio(input int frac);
        logic [63:0] term;
        logic [63:0] acc;
        term = 64'd1 << 62;
        acc  = term;
        for (int k = 1; k < 64; k++) begin
            term = udiv64(term >> frac, 64'(k));
            if (k % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        return (acc + (64'd1 << 29)) >> 30;
    endfunction

endpackage

// ===== rtl/core/yad_ram.sv =====
module yad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/yad_table.sv =====
module yad_table #(
    parameter int SIGMOID_ENTRIES = yad_pkg::SIG_ENTRIES_DEF,
    parameter int LOGIT_FRAC_BITS = yad_pkg::LOGIT_FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(SIGMOID_ENTRIES)-1:0] i_raddr,
    output logic [15:0]                        o_rdata,
    output logic                               o_ready
);
    import yad_pkg::*;

    localparam int AW   = $clog2(SIGMOID_ENTRIES);
    localparam int HALF = SIGMOID_ENTRIES / 2;
    localparam int KW   = $clog2(HALF + 1);
    localparam logic [63:0] RATIO = sig_ratio(LOGIT_FRAC_BITS);

    typedef enum logic [5:0] {
        F_PREP = 6'b000001,
        F_DIV  = 6'b000010,
        F_WPOS = 6'b000100,
        F_WNEG = 6'b001000,
        F_MUL  = 6'b010000,
        F_DONE = 6'b100000
    } t_fill_state;

    t_fill_state r_state, n_state;
    logic [KW-1:0] r_k;
    logic [32:0]   r_e;
    logic [33:0]   r_den;
    logic [33:0]   r_rem;
    logic [16:0]   r_nlo;
    logic [16:0]   r_quo;
    logic [4:0]    r_cnt;

    logic [33:0]   den;
    logic [48:0]   num;
    logic [34:0]   trial;
    logic          ge;
    logic [64:0]   prod;
    logic [65:0]   prod_rnd;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;

    always_comb begin
        den      = (34'd1 << 32) + {1'b0, r_e};
        num      = (49'd1 << 48) + {15'd0, den[33:1]};
        trial    = {r_rem, r_nlo[16]};
        ge       = trial >= {1'b0, r_den};
        prod     = r_e * RATIO[31:0];
        prod_rnd = {1'b0, prod} + (66'd1 << 31);
        we       = 1'b0;
        waddr    = AW'(HALF) + AW'(r_k);
        wdata    = (r_quo > 17'd65535) ? 16'hFFFF : r_quo[15:0];
        n_state  = r_state;
        unique case (r_state)
            F_PREP: n_state = F_DIV;
            F_DIV:  if (r_cnt == 5'd16) n_state = F_WPOS;
            F_WPOS: begin
                we      = r_k < KW'(HALF);
                n_state = F_WNEG;
            end
            F_WNEG: begin
                we      = r_k != '0;
                waddr   = AW'(HALF) - AW'(r_k);
                wdata   = 16'(17'h10000 - r_quo);
                n_state = (r_k == KW'(HALF)) ? F_DONE : F_MUL;
            end
            F_MUL:  n_state = F_PREP;
            F_DONE: n_state = F_DONE;
            default: n_state = F_PREP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_PREP;
            r_k     <= '0;
            r_e     <= 33'd1 << 32;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                F_PREP: begin
                    r_den <= den;
                    r_rem <= {2'b0, num[48:17]};
                    r_nlo <= num[16:0];
                    r_cnt <= '0;
                end
                F_DIV: begin
                    r_rem <= ge ? 34'(trial - {1'b0, r_den}) : trial[33:0];
                    r_nlo <= {r_nlo[15:0], 1'b0};
                    r_quo <= {r_quo[15:0], ge};
                    r_cnt <= r_cnt + 5'd1;
                end
                F_WNEG: if (r_k != KW'(HALF)) r_k <= r_k + KW'(1);
                F_MUL:  r_e <= prod_rnd[64:32];
                default: ;
            endcase
        end
    end

    yad_ram #(
        .WIDTH(16),
        .DEPTH(SIGMOID_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(i_raddr),
        .o_rdata(o_rdata)
    );

    assign o_ready = r_state == F_DONE;
endmodule

// ===== rtl/core/yad_front.sv =====
module yad_front #(
    parameter int SIGMOID_ENTRIES = yad_pkg::SIG_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  yad_pkg::t_in_word i_in_word,
    input  logic             i_table_ready,
    output logic             o_cmd_valid,
    output yad_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_pop
);
    import yad_pkg::*;

    localparam int QPW = $clog2(CMD_Q_DEPTH);

    t_cmd           r_q [CMD_Q_DEPTH];
    logic [QPW-1:0] r_wptr, r_rptr;
    logic [QPW:0]   r_count, n_count;
    logic           r_open, n_open;

    logic accept, keep, deq, is_box;
    t_cmd n_cmd;

    assign o_full  = (r_count == (QPW+1)'(CMD_Q_DEPTH)) || !i_table_ready;
    assign accept  = i_push && !o_full;
    assign is_box  = i_in_word.mode == MODE_BOX;
    // drop class words that arrive with no open anchor
    assign keep    = accept && (is_box || r_open);
    assign deq     = i_cmd_pop && (r_count != '0);

    always_comb begin
        n_cmd.is_box   = is_box;
        n_cmd.last     = i_in_word.last_class;
        n_cmd.lut_idx  = sig_index(is_box ? i_in_word.logit_obj : i_in_word.class_logit,
                                   SIGMOID_ENTRIES);
        n_cmd.logit_x  = i_in_word.logit_x;
        n_cmd.logit_y  = i_in_word.logit_y;
        n_cmd.logit_w  = i_in_word.logit_w;
        n_cmd.logit_h  = i_in_word.logit_h;
        n_cmd.cell_col = i_in_word.cell_col;
        n_cmd.cell_row = i_in_word.cell_row;
        n_cmd.prior_w  = i_in_word.prior_w;
        n_cmd.prior_h  = i_in_word.prior_h;

        n_count = r_count + (QPW+1)'(keep) - (QPW+1)'(deq);

        n_open = r_open;
        if (accept) begin
            if (is_box)                               n_open = 1'b1;
            else if (r_open && i_in_word.last_class) n_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_q[r_wptr] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_open  <= 1'b0;
        end else begin
            if (keep) r_wptr <= r_wptr + QPW'(1);
            if (deq)  r_rptr <= r_rptr + QPW'(1);
            r_count <= n_count;
            r_open  <= n_open;
        end
    end

    assign o_cmd_valid = r_count != '0;
    assign o_cmd       = r_q[r_rptr];
endmodule

// ===== rtl/core/yad_back.sv =====
module yad_back #(
    parameter int MAX_CLASSES     = yad_pkg::MAX_CLASSES_DEF,
    parameter int SIGMOID_ENTRIES = yad_pkg::SIG_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  yad_pkg::t_cfg                      i_cfg,
    input  logic                               i_cmd_valid,
    input  yad_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_pop,
    output logic [$clog2(SIGMOID_ENTRIES)-1:0] o_raddr,
    input  logic [15:0]                        i_rdata,
    output logic                               o_empty,
    input  logic                               i_pop,
    output yad_pkg::t_out_word                 o_out_word
);
    import yad_pkg::*;

    localparam int AW    = $clog2(SIGMOID_ENTRIES);
    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int DIV_W = 38;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_LOOK  = 13'b0000000000010,
        A_RP    = 13'b0000000000100,
        A_RQ    = 13'b0000000001000,
        A_M1    = 13'b0000000010000,
        A_M2    = 13'b0000000100000,
        A_M3    = 13'b0000001000000,
        A_DIV   = 13'b0000010000000,
        A_SUB   = 13'b0000100000000,
        A_MUL   = 13'b0001000000000,
        A_RND   = 13'b0010000000000,
        S_SCORE = 13'b0100000000000,
        S_PUSH  = 13'b1000000000000
    } t_back_state;

    t_back_state r_state;
    t_cmd        r_cmd, r_pend;
    logic [15:0] r_obj, r_best;
    logic [CNT_W-1:0] r_cnt, r_best_idx;
    logic        r_axis;
    logic [15:0] r_p, r_q;
    logic signed [39:0] r_pn;
    logic        r_neg;
    logic [31:0] r_sq;
    logic [43:0] r_m;
    logic [DIV_W-1:0] r_dq;
    logic [7:0]  r_rem;
    logic [5:0]  r_dcnt;
    logic signed [39:0] r_d;
    logic [28:0] r_bl;
    logic signed [56:0] r_ev;
    logic [44:0] r_sv;
    logic signed [15:0] r_left, r_top;
    logic [15:0] r_wid, r_hgt, r_score;
    logic        r_out_valid;
    t_out_word   r_out;

    logic signed [15:0] pos_raw, size_raw;
    logic [7:0]  cell_idx, grid, grid_eff;
    logic [11:0] prior;
    logic [12:0] net;
    logic [15:0] scale;
    logic signed [25:0] pos;
    logic [39:0] pn_abs;
    logic [8:0]  dtrial;
    logic        dge;
    logic signed [38:0] c16;
    logic [45:0] hb_sum;
    logic [46:0] b_sum;
    logic [29:0] hb16;
    logic [30:0] b16;
    logic [28:0] lim;
    logic [56:0] ev_abs;
    logic [33:0] eq;
    logic [15:0] edge_val;
    logic [21:0] sq_r;
    logic [15:0] size_val;
    logic        out_take, can_push;

    always_comb begin
        pos_raw  = r_axis ? r_pend.logit_y  : r_pend.logit_x;
        size_raw = r_axis ? r_pend.logit_h  : r_pend.logit_w;
        cell_idx = r_axis ? r_pend.cell_row : r_pend.cell_col;
        prior    = r_axis ? r_pend.prior_h  : r_pend.prior_w;
        grid     = r_axis ? i_cfg.grid_height : i_cfg.grid_width;
        net      = r_axis ? i_cfg.net_height  : i_cfg.net_width;
        scale    = r_axis ? i_cfg.scale_y     : i_cfg.scale_x;
        grid_eff = (grid == 8'd0) ? 8'd1 : grid;

        // 2p - 0.5 + cell, Q16 cells
        pos    = $signed({2'b0, cell_idx, 16'b0}) + $signed({9'b0, r_p, 1'b0}) - 26'sd32768;
        pn_abs = r_pn[39] ? 40'(-r_pn) : 40'(r_pn);

        dtrial = {r_rem, r_dq[DIV_W-1]};
        dge    = dtrial >= {1'b0, grid_eff};
        c16    = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});

        hb_sum = {1'b0, r_m, 1'b0} + 46'd32768;
        b_sum  = {1'b0, r_m, 2'b0} + 47'd32768;
        hb16   = hb_sum[45:16];
        b16    = b_sum[46:16];
        lim    = {net, 16'b0};

        // edge: round half to even from Q24, saturate to 16 bits signed
        ev_abs = r_ev[56] ? 57'(-r_ev) : 57'(r_ev);
        eq     = {1'b0, ev_abs[56:24]};
        if (ev_abs[23:0] > 24'h800000 || (ev_abs[23:0] == 24'h800000 && eq[0])) begin
            eq = eq + 34'd1;
        end
        if (!r_ev[56]) edge_val = (eq > 34'd32767) ? 16'h7FFF : eq[15:0];
        else           edge_val = (eq > 34'd32768) ? 16'h8000 : 16'(-eq);

        sq_r = {1'b0, r_sv[44:24]};
        if (r_sv[23:0] > 24'h800000 || (r_sv[23:0] == 24'h800000 && sq_r[0])) begin
            sq_r = sq_r + 22'd1;
        end
        size_val = (sq_r > 22'd65535) ? 16'hFFFF : sq_r[15:0];

        out_take = i_pop && r_out_valid;
        can_push = !r_out_valid || out_take;

        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
        unique case (r_state)
            A_RP:    o_raddr = AW'(sig_index(pos_raw, SIGMOID_ENTRIES));
            A_RQ:    o_raddr = AW'(sig_index(size_raw, SIGMOID_ENTRIES));
            default: o_raddr = i_cmd.lut_idx[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
        end else begin
            if (r_state == S_PUSH && can_push) r_out_valid <= 1'b1;
            else if (out_take)                 r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_IDLE;
                    if (r_cmd.is_box) begin
                        // open anchor, drop any that was open
                        r_pend <= r_cmd;
                        r_obj  <= i_rdata;
                        r_cnt  <= '0;
                    end else begin
                        if (r_cnt < CNT_W'(MAX_CLASSES)) begin
                            if (r_cnt == '0 || i_rdata > r_best) begin
                                r_best     <= i_rdata;
                                r_best_idx <= r_cnt;
                            end
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (r_cmd.last && r_obj > i_cfg.score_threshold) begin
                            r_axis  <= 1'b0;
                            r_state <= A_RP;
                        end
                    end
                end
                A_RP: r_state <= A_RQ;
                A_RQ: begin
                    r_p     <= i_rdata;
                    r_state <= A_M1;
                end
                A_M1: begin
                    r_q     <= i_rdata;
                    r_pn    <= pos * $signed({1'b0, net});
                    r_state <= A_M2;
                end
                A_M2: begin
                    r_sq    <= r_q * r_q;
                    r_neg   <= r_pn[39];
                    r_dq    <= pn_abs[DIV_W-1:0] + DIV_W'(grid_eff >> 1);
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= A_M3;
                end
                A_M3: begin
                    r_m     <= r_sq * prior;
                    r_state <= A_DIV;
                end
                A_DIV: begin
                    r_rem  <= dge ? 8'(dtrial - {1'b0, grid_eff}) : dtrial[7:0];
                    r_dq   <= {r_dq[DIV_W-2:0], dge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(DIV_W - 1)) r_state <= A_SUB;
                end
                A_SUB: begin
                    r_d     <= $signed({c16[38], c16}) - $signed({10'b0, hb16});
                    r_bl    <= (b16 > {2'b0, lim}) ? lim : b16[28:0];
                    r_state <= A_MUL;
                end
                A_MUL: begin
                    r_ev    <= r_d * $signed({1'b0, scale});
                    r_sv    <= r_bl * scale;
                    r_state <= A_RND;
                end
                A_RND: begin
                    if (r_axis) begin
                        r_top   <= edge_val;
                        r_hgt   <= size_val;
                        r_state <= S_SCORE;
                    end else begin
                        r_left  <= edge_val;
                        r_wid   <= size_val;
                        r_axis  <= 1'b1;
                        r_state <= A_RP;
                    end
                end
                S_SCORE: begin
                    r_score <= 16'(((r_obj * r_best) + 32'd32768) >> 16);
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (can_push) begin
                        r_out.box_left    <= r_left;
                        r_out.box_top     <= r_top;
                        r_out.box_width   <= r_wid;
                        r_out.box_height  <= r_hgt;
                        r_out.score       <= r_score;
                        r_out.class_index <= 8'(r_best_idx);
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;
endmodule

// ===== rtl/core/yolo_anchor_decode.sv =====
// Anchor decoder: box word opens an anchor, class words follow, last class closes it.
// In the back end a word reads the table in S_IDLE and updates the argmax in S_LOOK;
// the 4-word front queue takes a word per cycle until it fills. A kept anchor is
// decoded after its last class word: both axes in turn, each with the 38-step divide
// by the grid size, then score and output. Sync active-low reset; the sigmoid table
// then fills itself with full held high.
module yolo_anchor_decode #(
    parameter int MAX_CLASSES     = yad_pkg::MAX_CLASSES_DEF,
    parameter int SIGMOID_ENTRIES = yad_pkg::SIG_ENTRIES_DEF,
    parameter int LOGIT_FRAC_BITS = yad_pkg::LOGIT_FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  yad_pkg::t_in_word                  i_in_word,
    output logic                               empty,
    input  logic                               pop,
    output yad_pkg::t_out_word                 o_out_word,
    input  logic                               valid,
    output logic                               ready,
    input  logic [yad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [yad_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import yad_pkg::*;

    localparam int AW = $clog2(SIGMOID_ENTRIES);

    t_cfg          r_cfg;
    logic          table_ready;
    logic          cmd_valid, cmd_pop;
    t_cmd          cmd;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;

    // config port never stalls; an index past the last register is dropped
    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_THRESH:  r_cfg.score_threshold <= i_cfg_data;
                REG_NET_W:   r_cfg.net_width       <= i_cfg_data[12:0];
                REG_NET_H:   r_cfg.net_height      <= i_cfg_data[12:0];
                REG_GRID_W:  r_cfg.grid_width      <= i_cfg_data[7:0];
                REG_GRID_H:  r_cfg.grid_height     <= i_cfg_data[7:0];
                REG_SCALE_X: r_cfg.scale_x         <= i_cfg_data;
                REG_SCALE_Y: r_cfg.scale_y         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sigmoid table: fills itself after reset, then serves one read a cycle
    yad_table #(
        .SIGMOID_ENTRIES(SIGMOID_ENTRIES),
        .LOGIT_FRAC_BITS(LOGIT_FRAC_BITS)
    ) u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_raddr(raddr),
        .o_rdata(rdata),
        .o_ready(table_ready)
    );

    // front: accept words, drop orphan class words, precompute the table index
    yad_front #(
        .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_in_word    (i_in_word),
        .i_table_ready(table_ready),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // back: argmax, box decode sequencer and the output register
    yad_back #(
        .MAX_CLASSES    (MAX_CLASSES),
        .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_word (o_out_word)
    );
endmodule
